// ===== hdl/gbfas_pkg.sv =====
`timescale 1ns / 1ps

package gbfas_pkg;

	// default geometry
	localparam int GRID_COLS_DEF    = 64;
	localparam int GRID_ROWS_DEF    = 48;
	localparam int CELL_DEPTH_DEF   = 16;
	localparam int MAX_FEATURES_DEF = 1024;
	localparam int MAX_HITS_DEF     = 64;
	localparam int LEVELS_DEF       = 8;

	// fraction bits of a scaled cell position
	localparam int FRAC = 20;

	// commands
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_OUTSIDE = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_TRUNC   = 2'd3;

	// register indexes
	localparam logic [1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] REG_CPP_X    = 2'd2;
	localparam logic [1:0] REG_CPP_Y    = 2'd3;

	// register reset values
	localparam logic [15:0] CPP_RESET = 16'd6554;

	// rounding modes of the cell position
	localparam logic [1:0] RND_FLOOR = 2'd0;
	localparam logic [1:0] RND_CEIL  = 2'd1;
	localparam logic [1:0] RND_HALF  = 2'd2;

	// p / 2^FRAC under the given rounding mode
	function automatic logic signed [15:0] scale_div(input logic signed [34:0] p,
		input logic [1:0] mode);
		logic               neg;
		logic signed [35:0] pe;
		logic        [35:0] m;
		logic        [35:0] q;
		neg = p[34];
		pe  = 36'(p);
		m   = neg ? 36'(-pe) : 36'(pe);
		if (mode == RND_HALF) begin
			q = (m + (36'd1 << (FRAC - 1))) >> FRAC;
		end else if ((mode == RND_FLOOR) == neg) begin
			q = (m + (36'd1 << FRAC) - 36'd1) >> FRAC;
		end else begin
			q = m >> FRAC;
		end
		return neg ? -16'(q) : 16'(q);
	endfunction

endpackage

// ===== hdl/grid_bucketed_feature_area_search.sv =====
`timescale 1ns / 1ps

// channel   | handshake              | payload
// ----------+------------------------+------------------------------------------------
// input     | in_valid / in_ready    | command feature_index pos_x pos_y octave radius
//           |                        | min_level max_level
// result    | out_valid / out_ready  | hit_index hit last status
// config    | psel penable pwrite    | paddr pwdata prdata, pready tied high
//
// insert: 4 shared multiplies, rounding, fill read, slot and fill write-back, result
// query: setup, then a fill read per window cell and a slot read and test per stored slot
// clear: one fill entry zeroed per cycle
// after reset the same clearing pass runs, in_ready low
// a full result register stalls the walk; the fill memory port sets the pace

module grid_bucketed_feature_area_search #(
	parameter int GridCols    = gbfas_pkg::GRID_COLS_DEF,
	parameter int GridRows    = gbfas_pkg::GRID_ROWS_DEF,
	parameter int CellDepth   = gbfas_pkg::CELL_DEPTH_DEF,
	parameter int MaxFeatures = gbfas_pkg::MAX_FEATURES_DEF,
	parameter int MaxHits     = gbfas_pkg::MAX_HITS_DEF,
	parameter int Levels      = gbfas_pkg::LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input transactions
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [9:0]         feature_index,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [2:0]         octave,
	input  logic [11:0]        radius,
	input  logic [2:0]         min_level,
	input  logic signed [3:0]  max_level,
	// result transactions
	output logic               out_valid,
	input  logic               out_ready,
	output logic [9:0]         hit_index,
	output logic               hit,
	output logic               last,
	output logic [1:0]         status,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int NCells = GridCols * GridRows;
	localparam int NSlots = NCells * CellDepth;
	localparam int ColW   = $clog2(GridCols);
	localparam int RowW   = $clog2(GridRows);
	localparam int CellW  = $clog2(NCells);
	localparam int SlotW  = $clog2(NSlots);
	localparam int FillW  = $clog2(CellDepth + 1);
	localparam int HitW   = $clog2(MaxHits + 1);
	localparam int LvlW   = (Levels > 1) ? $clog2(Levels) : 1;
	localparam int DataW  = 10 + 16 + 16 + LvlW;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RESP, S_MUL, S_MULW, S_CALC, S_IFILL, S_IWAIT,
		S_QCELL, S_QFILL, S_QSLOT, S_QCHK, S_QEND
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [15:0] origin_x_q, origin_y_q;
	logic [15:0]        cpp_x_q, cpp_y_q;

	// latched transaction
	logic [1:0]         cmd_q;
	logic [9:0]         fi_q;
	logic signed [15:0] px_q, py_q;
	logic [2:0]         oct_q;
	logic [11:0]        r_q;
	logic [2:0]         minl_q;
	logic signed [3:0]  maxl_q;

	// sequencer registers
	logic [CellW-1:0]   clr_cnt_q;
	logic               clr_cmd_q;
	logic [1:0]         resp_status_q;
	logic [1:0]         k_q;
	logic signed [34:0] prod_q;
	logic [1:0]         prod_k_q;
	logic               prod_v_q;
	logic signed [15:0] bnd_q [4];
	logic [CellW-1:0]   cell_q;
	logic [SlotW-1:0]   base_q;
	logic [ColW-1:0]    col_q, x1_q;
	logic [RowW-1:0]    row_q, y0_q, y1_q;
	logic [CellW-1:0]   colbase_q;
	logic [FillW-1:0]   j_q, fill_q;
	logic               pend_v_q;
	logic [9:0]         pend_idx_q;
	logic [HitW-1:0]    n_q;

	// result register
	logic               out_valid_q;
	logic [9:0]         hit_index_q;
	logic               hit_q, last_q;
	logic [1:0]         status_q;

	// memories
	logic [FillW-1:0] fill_mem [NCells];
	logic [DataW-1:0] slot_mem [NSlots];
	logic [FillW-1:0] fill_rd_q;
	logic [DataW-1:0] slot_rd_q;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			cpp_x_q    <= gbfas_pkg::CPP_RESET;
			cpp_y_q    <= gbfas_pkg::CPP_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				gbfas_pkg::REG_ORIGIN_X: origin_x_q <= pwdata[15:0];
				gbfas_pkg::REG_ORIGIN_Y: origin_y_q <= pwdata[15:0];
				gbfas_pkg::REG_CPP_X:    cpp_x_q    <= pwdata[15:0];
				gbfas_pkg::REG_CPP_Y:    cpp_y_q    <= pwdata[15:0];
				default:                 ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			gbfas_pkg::REG_ORIGIN_X: prdata = 32'(origin_x_q);
			gbfas_pkg::REG_ORIGIN_Y: prdata = 32'(origin_y_q);
			gbfas_pkg::REG_CPP_X:    prdata = {16'd0, cpp_x_q};
			gbfas_pkg::REG_CPP_Y:    prdata = {16'd0, cpp_y_q};
			default:                 prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// shared multiplier operands: k[1] picks the axis, k[0] the high edge
	logic signed [17:0] mul_diff;
	logic signed [34:0] mul_w;
	logic signed [15:0] mul_pos, mul_org;
	logic [15:0]        mul_cpp;
	logic signed [17:0] mul_off;

	always_comb begin
		mul_pos = k_q[1] ? py_q : px_q;
		mul_org = k_q[1] ? origin_y_q : origin_x_q;
		mul_cpp = k_q[1] ? cpp_y_q : cpp_x_q;
		if (cmd_q == gbfas_pkg::CMD_QUERY) begin
			mul_off = k_q[0] ? 18'(signed'({1'b0, r_q})) : -18'(signed'({1'b0, r_q}));
		end else begin
			mul_off = '0;
		end
		mul_diff = 18'(mul_pos) - 18'(mul_org) + mul_off;
		mul_w    = 35'(mul_diff) * 35'(signed'({1'b0, mul_cpp}));
	end

	// rounding mode of the product being scaled
	logic [1:0] scale_mode;
	always_comb begin
		if (cmd_q == gbfas_pkg::CMD_QUERY) begin
			scale_mode = prod_k_q[0] ? gbfas_pkg::RND_CEIL : gbfas_pkg::RND_FLOOR;
		end else begin
			scale_mode = gbfas_pkg::RND_HALF;
		end
	end

	// insert cell and bounds
	logic ins_oob;
	logic [CellW-1:0] ins_cell;
	always_comb begin
		ins_oob = (bnd_q[0] < 16'sd0) || (32'(bnd_q[0]) >= GridCols) ||
			(bnd_q[2] < 16'sd0) || (32'(bnd_q[2]) >= GridRows) ||
			(32'(fi_q) >= MaxFeatures);
		ins_cell = CellW'(bnd_q[0][ColW-1:0]) * CellW'(GridRows) +
			CellW'(bnd_q[2][RowW-1:0]);
	end

	// query window clamped to the grid
	logic signed [15:0] x0c, x1c, y0c, y1c;
	logic               win_empty;
	always_comb begin
		x0c = (bnd_q[0] < 16'sd0) ? 16'sd0 : bnd_q[0];
		x1c = (32'(bnd_q[1]) > GridCols - 1) ? 16'(GridCols - 1) : bnd_q[1];
		y0c = (bnd_q[2] < 16'sd0) ? 16'sd0 : bnd_q[2];
		y1c = (32'(bnd_q[3]) > GridRows - 1) ? 16'(GridRows - 1) : bnd_q[3];
		win_empty = (x0c > x1c) || (y0c > y1c);
	end

	// fill memory port control
	logic [CellW-1:0] qcell;
	logic             fill_re, fill_we, fill_full;
	logic [CellW-1:0] fill_raddr, fill_waddr;
	logic [FillW-1:0] fill_wdata;
	always_comb begin
		qcell      = colbase_q + CellW'(row_q);
		fill_re    = (state_q == S_IFILL) || (state_q == S_QCELL);
		fill_raddr = (state_q == S_IFILL) ? cell_q : qcell;
		fill_full  = fill_rd_q >= FillW'(CellDepth);
		fill_we    = (state_q == S_CLR) || ((state_q == S_IWAIT) && !fill_full);
		fill_waddr = (state_q == S_CLR) ? clr_cnt_q : cell_q;
		fill_wdata = (state_q == S_CLR) ? '0 : fill_rd_q + FillW'(1);
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
		if (fill_re) begin
			fill_rd_q <= fill_mem[fill_raddr];
		end
	end

	// slot memory port control
	logic             slot_re, slot_we;
	logic [SlotW-1:0] slot_raddr, slot_waddr;
	logic [LvlW-1:0]  ins_oct;
	logic [DataW-1:0] slot_wdata;
	always_comb begin
		ins_oct    = (32'(oct_q) >= Levels) ? LvlW'(Levels - 1) : LvlW'(oct_q);
		slot_re    = (state_q == S_QSLOT);
		slot_raddr = base_q + SlotW'(j_q);
		slot_we    = (state_q == S_IWAIT) && !fill_full;
		slot_waddr = base_q + SlotW'(fill_rd_q);
		slot_wdata = {ins_oct, py_q, px_q, fi_q};
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		if (slot_re) begin
			slot_rd_q <= slot_mem[slot_raddr];
		end
	end

	// slot test against the query
	logic [9:0]         s_idx;
	logic signed [15:0] s_x, s_y;
	logic [LvlW-1:0]    s_oct;
	logic signed [16:0] dx, dy;
	logic [16:0]        adx, ady;
	logic               lvl_chk, lvl_ok, hit_now;
	always_comb begin
		s_idx   = slot_rd_q[9:0];
		s_x     = slot_rd_q[25:10];
		s_y     = slot_rd_q[41:26];
		s_oct   = slot_rd_q[DataW-1:42];
		dx      = 17'(s_x) - 17'(px_q);
		dy      = 17'(s_y) - 17'(py_q);
		adx     = dx[16] ? 17'(-dx) : 17'(dx);
		ady     = dy[16] ? 17'(-dy) : 17'(dy);
		lvl_chk = (minl_q != 3'd0) || !maxl_q[3];
		lvl_ok  = !lvl_chk || ((5'(s_oct) >= 5'(minl_q)) &&
			(maxl_q[3] || (5'(s_oct) <= 5'(maxl_q[2:0]))));
		hit_now = lvl_ok && (adx < 17'(r_q)) && (ady < 17'(r_q));
	end

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// window walk bookkeeping
	logic row_end, col_end, slot_end;
	always_comb begin
		row_end  = (row_q == y1_q);
		col_end  = (col_q == x1_q);
		slot_end = ((FillW + 1)'(j_q) + (FillW + 1)'(1)) >= (FillW + 1)'(fill_q);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			clr_cnt_q     <= '0;
			clr_cmd_q     <= 1'b0;
			resp_status_q <= gbfas_pkg::STAT_OK;
			k_q           <= '0;
			prod_v_q      <= 1'b0;
			pend_v_q      <= 1'b0;
			n_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			prod_v_q <= 1'b0;
			if (prod_v_q) begin
				bnd_q[prod_k_q] <= gbfas_pkg::scale_div(prod_q, scale_mode);
			end
			case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + CellW'(1);
					if (clr_cnt_q == CellW'(NCells - 1)) begin
						resp_status_q <= gbfas_pkg::STAT_OK;
						state_q       <= clr_cmd_q ? S_RESP : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q  <= command;
						fi_q   <= feature_index;
						px_q   <= pos_x;
						py_q   <= pos_y;
						oct_q  <= octave;
						r_q    <= radius;
						minl_q <= min_level;
						maxl_q <= max_level;
						k_q    <= '0;
						case (command)
							gbfas_pkg::CMD_CLEAR: begin
								clr_cnt_q <= '0;
								clr_cmd_q <= 1'b1;
								state_q   <= S_CLR;
							end
							gbfas_pkg::CMD_INSERT, gbfas_pkg::CMD_QUERY: begin
								state_q <= S_MUL;
							end
							default: begin
								resp_status_q <= gbfas_pkg::STAT_OK;
								state_q       <= S_RESP;
							end
						endcase
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						hit_index_q <= '0;
						hit_q       <= 1'b0;
						last_q      <= 1'b1;
						status_q    <= resp_status_q;
						state_q     <= S_IDLE;
					end
				end
				// the edge products, in turn, through the one multiplier
				S_MUL: begin
					prod_q   <= mul_w;
					prod_k_q <= k_q;
					prod_v_q <= 1'b1;
					k_q      <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						state_q <= S_MULW;
					end
				end
				S_MULW: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					if (cmd_q == gbfas_pkg::CMD_INSERT) begin
						if (ins_oob) begin
							resp_status_q <= gbfas_pkg::STAT_OUTSIDE;
							state_q       <= S_RESP;
						end else begin
							cell_q  <= ins_cell;
							state_q <= S_IFILL;
						end
					end else begin
						pend_v_q <= 1'b0;
						n_q      <= '0;
						col_q    <= x0c[ColW-1:0];
						x1_q     <= x1c[ColW-1:0];
						row_q    <= y0c[RowW-1:0];
						y0_q     <= y0c[RowW-1:0];
						y1_q     <= y1c[RowW-1:0];
						colbase_q <= CellW'(x0c[ColW-1:0]) * CellW'(GridRows);
						state_q  <= win_empty ? S_QEND : S_QCELL;
					end
				end
				S_IFILL: begin
					base_q  <= SlotW'(fill_raddr) * SlotW'(CellDepth);
					state_q <= S_IWAIT;
				end
				S_IWAIT: begin
					resp_status_q <= fill_full ? gbfas_pkg::STAT_FULL : gbfas_pkg::STAT_OK;
					state_q       <= S_RESP;
				end
				S_QCELL: begin
					base_q  <= SlotW'(fill_raddr) * SlotW'(CellDepth);
					j_q     <= '0;
					state_q <= S_QFILL;
				end
				S_QFILL: begin
					fill_q <= fill_rd_q;
					if (fill_rd_q != '0) begin
						state_q <= S_QSLOT;
					end else if (!row_end) begin
						row_q   <= row_q + RowW'(1);
						state_q <= S_QCELL;
					end else if (!col_end) begin
						col_q     <= col_q + ColW'(1);
						row_q     <= y0_q;
						colbase_q <= colbase_q + CellW'(GridRows);
						state_q   <= S_QCELL;
					end else begin
						state_q <= S_QEND;
					end
				end
				S_QSLOT: begin
					state_q <= S_QCHK;
				end
				S_QCHK: begin
					if (hit_now && (n_q == HitW'(MaxHits))) begin
						// one hit too many: close the list as truncated
						if (out_free) begin
							out_valid_q <= 1'b1;
							hit_index_q <= pend_idx_q;
							hit_q       <= 1'b1;
							last_q      <= 1'b1;
							status_q    <= gbfas_pkg::STAT_TRUNC;
							state_q     <= S_IDLE;
						end
					end else if (!hit_now || !pend_v_q || out_free) begin
						if (hit_now) begin
							if (pend_v_q) begin
								out_valid_q <= 1'b1;
								hit_index_q <= pend_idx_q;
								hit_q       <= 1'b1;
								last_q      <= 1'b0;
								status_q    <= gbfas_pkg::STAT_OK;
							end
							pend_v_q   <= 1'b1;
							pend_idx_q <= s_idx;
							n_q        <= n_q + HitW'(1);
						end
						if (!slot_end) begin
							j_q     <= j_q + FillW'(1);
							state_q <= S_QSLOT;
						end else if (!row_end) begin
							row_q   <= row_q + RowW'(1);
							state_q <= S_QCELL;
						end else if (!col_end) begin
							col_q     <= col_q + ColW'(1);
							row_q     <= y0_q;
							colbase_q <= colbase_q + CellW'(GridRows);
							state_q   <= S_QCELL;
						end else begin
							state_q <= S_QEND;
						end
					end
				end
				S_QEND: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						hit_index_q <= pend_v_q ? pend_idx_q : '0;
						hit_q       <= pend_v_q;
						last_q      <= 1'b1;
						status_q    <= gbfas_pkg::STAT_OK;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign hit_index = hit_index_q;
	assign hit       = hit_q;
	assign last      = last_q;
	assign status    = status_q;

endmodule

// ===== hdl/gbfas_checker.sv =====
`timescale 1ns / 1ps

module gbfas_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [9:0] hit_index,
	input logic       hit,
	input logic       last,
	input logic [1:0] status
);

	// a stalled result transaction stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit_index) && $stable(last))
		else $error("result dropped while stalled");

	// an item without a hit always closes its list
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> last && hit_index == 10'd0)
		else $error("empty result not final or index not zero");

	// truncation is flagged only on the final hit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == gbfas_pkg::STAT_TRUNC |-> last && hit)
		else $error("truncation flag on wrong item");

	// insert failures never carry a hit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == gbfas_pkg::STAT_OUTSIDE || status == gbfas_pkg::STAT_FULL)
		|-> !hit && last)
		else $error("insert status with a hit");

endmodule

bind grid_bucketed_feature_area_search gbfas_checker u_gbfas_checker (.*);
